@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker of the texture sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define TBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TBS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tbs_pkg.sv @@
// Shared types and constants of the bilinear texture sampler.
`default_nettype none

package tbs_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 24;
    localparam int CH_W       = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 17;
    localparam int CNT100_W   = 24;
    localparam int CMP_W      = 32;
    localparam int STORE_DEPTH = 65536;

    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;

    localparam logic [CNT_W-1:0]    CNT_MAX  = 17'h1FFFF;
    localparam logic [CNT100_W-1:0] CNT_STEP = 24'd100;

    // item kinds carried on tuser
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;  // unused kind, ignored

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CUTOFF = 2'd2;

    // per-item sideband that rides along the pipeline
    typedef struct packed {
        logic [1:0]          op;
        logic [ADDR_W-1:0]   idx;
        logic [DATA_W-1:0]   val;
        logic                alpha_on;
        logic                cnt_nz;
        logic [CNT100_W-1:0] cnt100p;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/core/bilinear_texture_sampler_wrap.sv @@
// Top level of the bilinear texture sampler with wrap addressing and cutout.
// Coordinates wrap through a bit-serial modulo pipeline, one dividend bit per stage.
// Throughput: one transaction per cycle; a stall freezes every stage at once.
// Reset (synchronous, active low) clears stage valids and alpha statistics and
// loads width 256, height 256, cutoff 128; the texel memories are not cleared.
`default_nettype none

module bilinear_texture_sampler_wrap #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // texel_index[15:0], texel_value[47:16], coord_u[71:48], coord_v[95:72]
    input  wire logic [tbs_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // op[1:0]
    input  wire logic [tbs_pkg::S_TUSER_W-1:0]     i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], discard[32], zero[39:33]
    output logic [tbs_pkg::M_TDATA_W-1:0]          o_m_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [tbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbs_pkg::CFG_W-1:0]         i_cfg_data
);
    import tbs_pkg::*;

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int LIM_W = 2 * DW + 7;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] r);
        if (r == '0) return DW'(1);
        if (32'(r) > MAX_DIM) return DW'(MAX_DIM);
        return DW'(r);
    endfunction

    logic            en, acc;
    logic [DW-1:0]   r_tex_w, r_tex_h;
    logic [CH_W-1:0] r_cutoff;
    logic [CH_W-1:0] r_max_alpha;
    logic [CNT_W-1:0]    r_count;
    logic [CNT100_W-1:0] r_cnt100p;
    logic [2*DW-1:0] r_area;
    logic [LIM_W-1:0] r_lim;
    logic [CH_W-1:0] in_alpha;
    t_side           in_side;

    logic                 c_valid, f_valid, b_valid;
    t_side                c_side, f_side;
    logic [FRAC_BITS-1:0] c_tx, c_ty, f_tx, f_ty;
    logic [DW-1:0]        c_x0, c_x1, c_y0, c_y1;
    logic [DATA_W-1:0]    f_texel [4];
    logic [CH_W-1:0]      b_red, b_green, b_blue, b_alpha;
    logic                 b_discard;

    // whole pipeline advances unless the output holds an untaken result
    assign en         = !b_valid || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;
    assign in_alpha   = i_s_tdata[47:40];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w  <= clamp_dim(9'd256);
            r_tex_h  <= clamp_dim(9'd256);
            r_cutoff <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEX_WIDTH:    r_tex_w  <= clamp_dim(i_cfg_data);
                REG_TEX_HEIGHT:   r_tex_h  <= clamp_dim(i_cfg_data);
                REG_ALPHA_CUTOFF: r_cutoff <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // 95 percent of texture size, scaled by 100
    always_ff @(posedge i_clk) begin
        r_area <= (2*DW)'(r_tex_w) * (2*DW)'(r_tex_h);
        r_lim  <= LIM_W'(r_area) * LIM_W'(95);
    end

    // alpha statistics, updated as items are accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_alpha <= '0;
            r_count     <= '0;
            r_cnt100p   <= CNT_STEP;
        end else if (acc) begin
            case (i_s_tuser)
                OP_BEGIN: begin
                    r_max_alpha <= '0;
                    r_count     <= '0;
                    r_cnt100p   <= CNT_STEP;
                end
                OP_WRITE: begin
                    if (in_alpha > r_max_alpha) r_max_alpha <= in_alpha;
                    if (in_alpha < r_cutoff && r_count != CNT_MAX) begin
                        r_count   <= r_count + CNT_W'(1);
                        r_cnt100p <= r_cnt100p + CNT_STEP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        in_side.op       = i_s_tuser;
        in_side.idx      = i_s_tdata[15:0];
        in_side.val      = i_s_tdata[47:16];
        in_side.alpha_on = r_max_alpha != '0;
        in_side.cnt_nz   = r_count != '0;
        in_side.cnt100p  = r_cnt100p;
    end

    tbs_coord #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_side  (in_side),
        .i_u     (i_s_tdata[71:48]),
        .i_v     (i_s_tdata[95:72]),
        .i_w     (r_tex_w),
        .i_h     (r_tex_h),
        .o_valid (c_valid),
        .o_side  (c_side),
        .o_tx    (c_tx),
        .o_ty    (c_ty),
        .o_x0    (c_x0),
        .o_x1    (c_x1),
        .o_y0    (c_y0),
        .o_y1    (c_y1)
    );

    tbs_fetch #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_side  (c_side),
        .i_tx    (c_tx),
        .i_ty    (c_ty),
        .i_x0    (c_x0),
        .i_x1    (c_x1),
        .i_y0    (c_y0),
        .i_y1    (c_y1),
        .i_w     (r_tex_w),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_tx    (f_tx),
        .o_ty    (f_ty),
        .o_texel (f_texel)
    );

    tbs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (f_valid),
        .i_side    (f_side),
        .i_tx      (f_tx),
        .i_ty      (f_ty),
        .i_texel   (f_texel),
        .i_lim     (CMP_W'(r_lim)),
        .i_cutoff  (r_cutoff),
        .o_valid   (b_valid),
        .o_red     (b_red),
        .o_green   (b_green),
        .o_blue    (b_blue),
        .o_alpha   (b_alpha),
        .o_discard (b_discard)
    );

    assign o_m_tvalid = b_valid;
    assign o_m_tdata  = {7'd0, b_discard, b_alpha, b_blue, b_green, b_red};

endmodule

`default_nettype wire

@@ rtl/core/tbs_coord.sv @@
// Coordinate stage: half-texel offset, floor, and pipelined modulo wrap.
`default_nettype none

module tbs_coord #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8,
    parameter int DW        = $clog2(MAX_DIM + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire tbs_pkg::t_side                 i_side,
    input  wire logic [tbs_pkg::COORD_W-1:0]    i_u,
    input  wire logic [tbs_pkg::COORD_W-1:0]    i_v,
    input  wire logic [DW-1:0]                  i_w,
    input  wire logic [DW-1:0]                  i_h,
    output logic                                o_valid,
    output tbs_pkg::t_side                      o_side,
    output logic [FRAC_BITS-1:0]                o_tx,
    output logic [FRAC_BITS-1:0]                o_ty,
    output logic [DW-1:0]                       o_x0,
    output logic [DW-1:0]                       o_x1,
    output logic [DW-1:0]                       o_y0,
    output logic [DW-1:0]                       o_y1
);
    import tbs_pkg::*;

    localparam int FW = COORD_W + 1;
    localparam int IW = FW - FRAC_BITS;
    localparam int NS = IW + 1;
    localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

    // one restoring remainder step
    function automatic logic [DW-1:0] rem_step(input logic [DW-1:0] r, input logic b,
                                               input logic [DW-1:0] d);
        logic [DW:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) t = t - {1'b0, d};
        return t[DW-1:0];
    endfunction

    // (r - c) mod d with r, c < d
    function automatic logic [DW-1:0] fix_mod(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                              input logic [DW-1:0] d);
        logic [DW:0] t;
        if (r >= c) t = {1'b0, r} - {1'b0, c};
        else        t = {1'b0, r} + {1'b0, d} - {1'b0, c};
        return t[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] next_wrap(input logic [DW-1:0] m, input logic [DW-1:0] d);
        logic [DW:0] p;
        p = {1'b0, m} + (DW+1)'(1);
        return (p == {1'b0, d}) ? '0 : p[DW-1:0];
    endfunction

    logic [FW-1:0] fu, fv;
    logic [IW-1:0] xi, yi;

    logic                 r_valid [NS];
    t_side                r_side  [NS];
    logic [FRAC_BITS-1:0] r_tx    [NS];
    logic [FRAC_BITS-1:0] r_ty    [NS];
    logic [IW-1:0]        r_du    [NS];
    logic [IW-1:0]        r_dv    [NS];
    logic [DW-1:0]        r_ru    [NS];
    logic [DW-1:0]        r_rv    [NS];
    logic [DW-1:0]        r_cw    [NS];
    logic [DW-1:0]        r_ch    [NS];

    logic                 r_f1_valid, r_f2_valid;
    t_side                r_f1_side, r_f2_side;
    logic [FRAC_BITS-1:0] r_f1_tx, r_f1_ty, r_f2_tx, r_f2_ty;
    logic [DW-1:0]        r_f1_x, r_f1_y, r_f2_x0, r_f2_x1, r_f2_y0, r_f2_y1;

    // offset by one half and split into integer and fraction
    always_comb begin
        fu = {i_u[COORD_W-1], i_u} - HALF;
        fv = {i_v[COORD_W-1], i_v} - HALF;
        xi = fu[FW-1:FRAC_BITS];
        yi = fv[FW-1:FRAC_BITS];
    end

    // stage 0: bias the signed integer part into an unsigned dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_tx[0]   <= fu[FRAC_BITS-1:0];
            r_ty[0]   <= fv[FRAC_BITS-1:0];
            r_du[0]   <= {~xi[IW-1], xi[IW-2:0]};
            r_dv[0]   <= {~yi[IW-1], yi[IW-2:0]};
            r_ru[0]   <= '0;
            r_rv[0]   <= '0;
            r_cw[0]   <= '0;
            r_ch[0]   <= '0;
        end
    end

    // remainder stages: one dividend bit each; the bias remainder runs alongside
    for (genvar k = 1; k < NS; k++) begin : g_rem
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_tx[k]   <= r_tx[k-1];
                r_ty[k]   <= r_ty[k-1];
                r_du[k]   <= r_du[k-1] << 1;
                r_dv[k]   <= r_dv[k-1] << 1;
                r_ru[k]   <= rem_step(r_ru[k-1], r_du[k-1][IW-1], i_w);
                r_rv[k]   <= rem_step(r_rv[k-1], r_dv[k-1][IW-1], i_h);
                r_cw[k]   <= rem_step(r_cw[k-1], k == 1, i_w);
                r_ch[k]   <= rem_step(r_ch[k-1], k == 1, i_h);
            end
        end
    end

    // remove the bias, then form the right and lower neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (i_en) begin
            r_f1_valid <= r_valid[NS-1];
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_side <= r_side[NS-1];
            r_f1_tx   <= r_tx[NS-1];
            r_f1_ty   <= r_ty[NS-1];
            r_f1_x    <= fix_mod(r_ru[NS-1], r_cw[NS-1], i_w);
            r_f1_y    <= fix_mod(r_rv[NS-1], r_ch[NS-1], i_h);
            r_f2_side <= r_f1_side;
            r_f2_tx   <= r_f1_tx;
            r_f2_ty   <= r_f1_ty;
            r_f2_x0   <= r_f1_x;
            r_f2_y0   <= r_f1_y;
            r_f2_x1   <= next_wrap(r_f1_x, i_w);
            r_f2_y1   <= next_wrap(r_f1_y, i_h);
        end
    end

    assign o_valid = r_f2_valid;
    assign o_side  = r_f2_side;
    assign o_tx    = r_f2_tx;
    assign o_ty    = r_f2_ty;
    assign o_x0    = r_f2_x0;
    assign o_x1    = r_f2_x1;
    assign o_y0    = r_f2_y0;
    assign o_y1    = r_f2_y1;

endmodule

`default_nettype wire

@@ rtl/core/tbs_fetch.sv @@
// Texel fetch: row-major addressing and four replicated texel memories.
`default_nettype none

module tbs_fetch #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8,
    parameter int DW        = $clog2(MAX_DIM + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire tbs_pkg::t_side                i_side,
    input  wire logic [FRAC_BITS-1:0]          i_tx,
    input  wire logic [FRAC_BITS-1:0]          i_ty,
    input  wire logic [DW-1:0]                 i_x0,
    input  wire logic [DW-1:0]                 i_x1,
    input  wire logic [DW-1:0]                 i_y0,
    input  wire logic [DW-1:0]                 i_y1,
    input  wire logic [DW-1:0]                 i_w,
    output logic                               o_valid,
    output tbs_pkg::t_side                     o_side,
    output logic [FRAC_BITS-1:0]               o_tx,
    output logic [FRAC_BITS-1:0]               o_ty,
    output logic [tbs_pkg::DATA_W-1:0]         o_texel [4]
);
    import tbs_pkg::*;

    localparam int SW = (2 * DW + 1 > ADDR_W) ? 2 * DW + 1 : ADDR_W;

    logic [SW-1:0] s00, s10, s01, s11;

    logic                 r_a_valid, r_m_valid;
    t_side                r_a_side, r_m_side;
    logic [FRAC_BITS-1:0] r_a_tx, r_a_ty, r_m_tx, r_m_ty;
    logic [ADDR_W-1:0]    r_addr [4];
    logic [DATA_W-1:0]    r_rd   [4];
    logic                 wr_en;

    // corner addresses, row times width plus column
    always_comb begin
        s00 = SW'(i_y0) * SW'(i_w) + SW'(i_x0);
        s10 = SW'(i_y0) * SW'(i_w) + SW'(i_x1);
        s01 = SW'(i_y1) * SW'(i_w) + SW'(i_x0);
        s11 = SW'(i_y1) * SW'(i_w) + SW'(i_x1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side  <= i_side;
            r_a_tx    <= i_tx;
            r_a_ty    <= i_ty;
            r_addr[0] <= s00[ADDR_W-1:0];
            r_addr[1] <= s10[ADDR_W-1:0];
            r_addr[2] <= s01[ADDR_W-1:0];
            r_addr[3] <= s11[ADDR_W-1:0];
            r_m_side  <= r_a_side;
            r_m_tx    <= r_a_tx;
            r_m_ty    <= r_a_ty;
        end
    end

    // texel writes land in every copy, in item order with the reads
    assign wr_en = r_a_valid && (r_a_side.op == OP_WRITE);

    for (genvar g = 0; g < 4; g++) begin : g_mem
        logic [DATA_W-1:0] r_mem [STORE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (wr_en) r_mem[r_a_side.idx] <= r_a_side.val;
                r_rd[g] <= r_mem[r_addr[g]];
            end
        end

        assign o_texel[g] = r_rd[g];
    end

    assign o_valid = r_m_valid;
    assign o_side  = r_m_side;
    assign o_tx    = r_m_tx;
    assign o_ty    = r_m_ty;

endmodule

`default_nettype wire

@@ rtl/core/tbs_blend.sv @@
// Bilinear blend: weights, per-channel products, sums, alpha and cutout test.
`default_nettype none

module tbs_blend #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire tbs_pkg::t_side                i_side,
    input  wire logic [FRAC_BITS-1:0]          i_tx,
    input  wire logic [FRAC_BITS-1:0]          i_ty,
    input  wire logic [tbs_pkg::DATA_W-1:0]    i_texel [4],
    input  wire logic [tbs_pkg::CMP_W-1:0]     i_lim,
    input  wire logic [tbs_pkg::CH_W-1:0]      i_cutoff,
    output logic                               o_valid,
    output logic [tbs_pkg::CH_W-1:0]           o_red,
    output logic [tbs_pkg::CH_W-1:0]           o_green,
    output logic [tbs_pkg::CH_W-1:0]           o_blue,
    output logic [tbs_pkg::CH_W-1:0]           o_alpha,
    output logic                               o_discard
);
    import tbs_pkg::*;

    localparam int WW  = 2 * FRAC_BITS + 1;
    localparam int PW  = CH_W + WW;
    localparam int SMW = PW + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] sx, sy, tx, ty;

    logic              r1_valid, r2_valid, r3_valid, r_out_valid;
    t_side             r1_side, r2_side, r3_side;
    logic [WW-1:0]     r1_w  [4];
    logic [DATA_W-1:0] r1_t  [4];
    logic [PW-1:0]     r2_p  [4][4];
    logic [CH_W-1:0]   r3_ch [4];
    logic [SMW-1:0]    sum   [4];

    logic            cut_on;
    logic [CH_W-1:0] alpha_v;
    logic [CH_W-1:0] r_red, r_green, r_blue, r_alpha;
    logic            r_discard;

    always_comb begin
        tx = {1'b0, i_tx};
        ty = {1'b0, i_ty};
        sx = ONE - tx;
        sy = ONE - ty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid && (r3_side.op == OP_SAMPLE);
        end
    end

    // corner weights
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_w[0] <= WW'(sx) * WW'(sy);
            r1_w[1] <= WW'(tx) * WW'(sy);
            r1_w[2] <= WW'(sx) * WW'(ty);
            r1_w[3] <= WW'(tx) * WW'(ty);
            r1_t    <= i_texel;
            r2_side <= r1_side;
            r3_side <= r2_side;
        end
    end

    // channel times weight; channel 0 blue, 1 green, 2 red, 3 alpha
    for (genvar c = 0; c < 4; c++) begin : g_chan
        for (genvar j = 0; j < 4; j++) begin : g_corner
            always_ff @(posedge i_clk) begin
                if (i_en) r2_p[c][j] <= PW'(r1_t[j][CH_W*c +: CH_W]) * PW'(r1_w[j]);
            end
        end

        assign sum[c] = SMW'(r2_p[c][0]) + SMW'(r2_p[c][1]) +
                        SMW'(r2_p[c][2]) + SMW'(r2_p[c][3]);

        always_ff @(posedge i_clk) begin
            if (i_en) r3_ch[c] <= sum[c][2*FRAC_BITS +: CH_W];
        end
    end

    // missing alpha forces opaque; cutout needs 100*(count+1) <= 95*size
    always_comb begin
        alpha_v = r3_side.alpha_on ? r3_ch[3] : '1;
        cut_on  = r3_side.alpha_on && r3_side.cnt_nz &&
                  (CMP_W'(r3_side.cnt100p) <= i_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red     <= r3_ch[2];
            r_green   <= r3_ch[1];
            r_blue    <= r3_ch[0];
            r_alpha   <= alpha_v;
            r_discard <= cut_on && (alpha_v < i_cutoff);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_alpha   = r_alpha;
    assign o_discard = r_discard;

endmodule

`default_nettype wire

@@ rtl/core/tbs_checker.sv @@
// Port-level checker for the texture sampler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module tbs_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [tbs_pkg::M_TDATA_W-1:0]     o_m_tdata
);

    // input side stalls only while a result waits
    `TBS_ASSERT(a_ready_rule, i_clk, i_rst_n, o_s_tready == (!o_m_tvalid || i_m_tready), "tready mismatch")

    // a held result keeps its data
    `TBS_ASSERT(a_hold_data, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "data moved")

    // padding bits stay zero
    `TBS_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[39:33] == 7'd0, "pad set")

    // reset empties the pipeline
    `TBS_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "valid after reset")

endmodule

bind bilinear_texture_sampler_wrap tbs_checker u_tbs_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the bilinear texture sampler: directed and random stream traffic.
`default_nettype none

module tb_top;
    import tbs_pkg::*;

    localparam int SHIFT_LATENCY = 40;    // drain wait, above the pipeline latency with margin
    localparam int IDLE_LIMIT    = 5000;  // cycles with no transaction before giving up

    typedef struct packed {
        logic          discard;
        logic [7:0]    alpha;
        logic [7:0]    blue;
        logic [7:0]    green;
        logic [7:0]    red;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_data;

    bilinear_texture_sampler_wrap i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // shadow of the sampler state
    logic [31:0] texels [STORE_DEPTH];
    bit          texel_known [STORE_DEPTH];
    int unsigned peak_alpha;
    int unsigned low_alpha_count;
    int unsigned reg_width, reg_height, reg_cutoff;

    t_pixel      pixel_queue [$];
    int          error_count;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;

    function automatic int unsigned eff_dim(int unsigned r);
        if (r < 1) return 1;
        if (r > 256) return 256;
        return r;
    endfunction

    function automatic int unsigned wrap_dim(longint c, int unsigned n);
        longint m;
        m = c % longint'(n);
        if (m < 0) m += n;
        return int'(m);
    endfunction

    // texel addresses of the four neighbors for a position
    function automatic void neighbors(logic [23:0] u, logic [23:0] v,
                                      output int unsigned addr [4],
                                      output int unsigned fx, output int unsigned fy);
        int unsigned w, h, x0, x1, y0, y1;
        longint fu, fv, xi, yi;
        w  = eff_dim(reg_width);
        h  = eff_dim(reg_height);
        fu = longint'($signed(u)) - 128;
        fv = longint'($signed(v)) - 128;
        fx = int'(fu & 255);
        fy = int'(fv & 255);
        xi = fu >>> 8;
        yi = fv >>> 8;
        x0 = wrap_dim(xi, w);
        x1 = wrap_dim(xi + 1, w);
        y0 = wrap_dim(yi, h);
        y1 = wrap_dim(yi + 1, h);
        addr[0] = (y0 * w + x0) & 16'hFFFF;
        addr[1] = (y0 * w + x1) & 16'hFFFF;
        addr[2] = (y1 * w + x0) & 16'hFFFF;
        addr[3] = (y1 * w + x1) & 16'hFFFF;
    endfunction

    function automatic bit all_known(logic [23:0] u, logic [23:0] v);
        int unsigned addr [4];
        int unsigned fx, fy;
        neighbors(u, v, addr, fx, fy);
        return texel_known[addr[0]] && texel_known[addr[1]] &&
               texel_known[addr[2]] && texel_known[addr[3]];
    endfunction

    // expected filtered pixel for a sample
    function automatic t_pixel filter_pixel(logic [23:0] u, logic [23:0] v);
        int unsigned addr [4];
        int unsigned fx, fy, wt [4], ch [4], acc;
        longint      area;
        bit          cut_on;
        t_pixel      px;
        neighbors(u, v, addr, fx, fy);
        wt[0] = (256 - fx) * (256 - fy);
        wt[1] = fx * (256 - fy);
        wt[2] = (256 - fx) * fy;
        wt[3] = fx * fy;
        for (int k = 0; k < 4; k++) begin
            acc = 0;
            for (int n = 0; n < 4; n++)
                acc += ((texels[addr[n]] >> (8 * k)) & 32'hFF) * wt[n];
            ch[k] = (acc >> 16) & 8'hFF;
        end
        if (peak_alpha == 0) ch[3] = 255;
        area   = longint'(eff_dim(reg_width)) * eff_dim(reg_height);
        cut_on = peak_alpha != 0 && low_alpha_count > 0 &&
                 longint'(low_alpha_count) < (area * 95) / 100;
        px.blue    = 8'(ch[0]);
        px.green   = 8'(ch[1]);
        px.red     = 8'(ch[2]);
        px.alpha   = 8'(ch[3]);
        px.discard = cut_on && ch[3] < reg_cutoff;
        return px;
    endfunction

    // update shadow state for an accepted transaction
    task automatic track_item(logic [1:0] op, logic [15:0] idx, logic [31:0] val,
                              logic [23:0] u, logic [23:0] v);
        case (op)
            OP_BEGIN: begin
                peak_alpha      = 0;
                low_alpha_count = 0;
            end
            OP_WRITE: begin
                texels[idx]      = val;
                texel_known[idx] = 1'b1;
                if (val[31:24] > peak_alpha) peak_alpha = val[31:24];
                if (val[31:24] < reg_cutoff && low_alpha_count < CNT_MAX)
                    low_alpha_count++;
            end
            OP_SAMPLE: pixel_queue.push_back(filter_pixel(u, v));
            default: ;
        endcase
    endtask

    // drive one input transaction, in bursts with random gaps
    task automatic send_item(logic [1:0] op, logic [15:0] idx, logic [31:0] val,
                             logic [23:0] u, logic [23:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, u, val, idx};
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        track_item(op, idx, val, u, v);
    endtask

    task automatic send_sample(logic [23:0] u, logic [23:0] v);
        send_item(OP_SAMPLE, 16'($urandom), $urandom, u, v);
    endtask

    // wait for every pixel, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (SHIFT_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_TEX_WIDTH:  reg_width  = value & 9'h1FF;
            REG_TEX_HEIGHT: reg_height = value & 9'h1FF;
            default:        reg_cutoff = value & 8'hFF;
        endcase
    endtask

    task automatic set_texture(int unsigned w_reg, int unsigned h_reg, int unsigned cutoff);
        wait_idle();
        write_reg(REG_TEX_WIDTH, w_reg);
        write_reg(REG_TEX_HEIGHT, h_reg);
        write_reg(REG_ALPHA_CUTOFF, cutoff);
    endtask

    function automatic logic [31:0] texel_word(bit no_alpha);
        logic [31:0] val;
        val = $urandom;
        if (no_alpha) val[31:24] = 8'h00;
        else if ($urandom_range(0, 7) == 0) val[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return val;
    endfunction

    // load the whole texture when small, else a 6x6 patch around the wrap corner
    task automatic load_texture(bit no_alpha);
        int unsigned w, h, x, y;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        send_item(OP_BEGIN, 16'($urandom), $urandom, 24'($urandom), 24'($urandom));
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (w * h > 64 && (r > 3 && r < h - 2 || c > 3 && c < w - 2)) continue;
                send_item(OP_WRITE, 16'((r * w + c) & 16'hFFFF), texel_word(no_alpha),
                          24'($urandom), 24'($urandom));
            end
        end
    endtask

    // position whose four neighbors are all loaded
    function automatic logic [47:0] pick_position();
        logic [23:0] u, v;
        int          w, h, span_u, span_v;
        for (int k = 0; k < 8; k++) begin
            u = $urandom;
            v = $urandom;
            if (all_known(u, v)) return {v, u};
        end
        w      = eff_dim(reg_width);
        h      = eff_dim(reg_height);
        span_u = 32000 / w;
        span_v = 32000 / h;
        u = 24'((($urandom_range(0, 4) - 2) + w * ($urandom_range(0, 2 * span_u) - span_u))
                * 256 + 128 + $urandom_range(0, 255));
        v = 24'((($urandom_range(0, 4) - 2) + h * ($urandom_range(0, 2 * span_v) - span_v))
                * 256 + 128 + $urandom_range(0, 255));
        return {v, u};
    endfunction

    // random mix: mostly samples and rewrites, some unused ops and rare reloads
    task automatic random_traffic(int count, bit no_alpha);
        logic [47:0] pos;
        int unsigned pick, w, h;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pos = pick_position();
                send_sample(pos[23:0], pos[47:24]);
            end else if (pick < 80) begin
                send_item(OP_WRITE, 16'($urandom_range(0, w * h - 1)), texel_word(no_alpha),
                          24'($urandom), 24'($urandom));
            end else if (pick < 90) begin
                send_item(OP_WRITE, 16'($urandom), texel_word(no_alpha),
                          24'($urandom), 24'($urandom));
            end else if (pick < 98) begin
                send_item(OP_RSVD, 16'($urandom), $urandom, 24'($urandom), 24'($urandom));
            end else begin
                load_texture(no_alpha);
            end
        end
    endtask

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker: a transaction completes on the next rising edge
    always @(negedge i_clk) begin
        t_pixel got, want;
        got = m_tdata[32:0];
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pixel_queue.size() == 0) begin
                report("unexpected pixel", 32'(got), 0);
            end else begin
                want = pixel_queue.pop_front();
                if (got.red != want.red) report("red", got.red, want.red);
                if (got.green != want.green) report("green", got.green, want.green);
                if (got.blue != want.blue) report("blue", got.blue, want.blue);
                if (got.alpha != want.alpha) report("alpha", got.alpha, want.alpha);
                if (got.discard != want.discard) report("discard", got.discard, want.discard);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(negedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver backpressure: mode switches now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= $urandom_range(0, 7) != 0;
        endcase
    end

    task automatic test_reset_defaults();
        reg_width  = 256;
        reg_height = 256;
        reg_cutoff = 128;
        load_texture(1'b0);
        send_sample(24'h800000, 24'h800000);
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h000000, 24'h000080);
        send_sample(24'h000080, 24'h0000FF);
        send_sample(24'hFFFF80, 24'h7FFFFF);
        send_item(OP_RSVD, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_traffic(30, 1'b0);
    endtask

    task automatic test_no_alpha();
        set_texture(8, 8, 200);
        load_texture(1'b1);
        send_sample(24'h000180, 24'h000240);
        random_traffic(25, 1'b1);
    endtask

    task automatic test_dim_extremes();
        set_texture(0, 0, 255);
        load_texture(1'b0);
        send_sample(24'h800000, 24'h7FFFFF);
        random_traffic(20, 1'b0);
        set_texture(511, 300, 0);
        load_texture(1'b0);
        random_traffic(30, 1'b0);
        set_texture(1, 256, 64);
        load_texture(1'b0);
        random_traffic(30, 1'b0);
        set_texture(256, 1, 192);
        load_texture(1'b0);
        random_traffic(30, 1'b0);
    endtask

    task automatic test_small_textures();
        set_texture(7, 5, 128);
        load_texture(1'b0);
        random_traffic(30, 1'b0);
        set_texture(32, 32, 250);
        load_texture(1'b0);
        random_traffic(40, 1'b0);
        set_texture(3, 200, 100);
        load_texture(1'b0);
        // cutoff change between load and sample
        wait_idle();
        write_reg(REG_ALPHA_CUTOFF, 255);
        random_traffic(40, 1'b0);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_BEGIN;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = REG_TEX_WIDTH;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        burst_left  = 0;
        stall_mode  = 0;
        peak_alpha  = 0;
        low_alpha_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_no_alpha();
        test_dim_extremes();
        test_small_textures();
        wait_idle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
